// ----- rtl/nadf_pkg.sv -----
package nadf_pkg;

    // Input modes.
    localparam logic [1:0] MODE_DEC  = 2'd0;
    localparam logic [1:0] MODE_HUND = 2'd1;
    localparam logic [1:0] MODE_HEX  = 2'd2;
    localparam logic [1:0] MODE_BYTE = 2'd3;

    // Geometry and format constants.
    localparam int unsigned VALUE_W   = 32;
    localparam int unsigned DIGITS    = 10;
    localparam int unsigned BCD_W     = 4 * DIGITS;
    localparam logic [12:0] CHAR_PITCH = 13'd12;

    // Digit positions counted from the most significant decimal digit.
    localparam logic [3:0] POS_UNITS    = 4'd9;
    localparam logic [3:0] POS_TENS     = 4'd8;
    localparam logic [3:0] POS_HUNDREDS = 4'd7;
    localparam logic [3:0] POS_HEX_LO   = 4'd1;

    // Character codes.
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_NINE  = 8'h39;
    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_UPPER_F = 8'h46;
    localparam logic [7:0] ASCII_DOT   = 8'h2E;
    localparam logic [7:0] ASCII_HEX_OFS = 8'h37;

    localparam logic [15:0] BG_WHITE = 16'hFFFF;
    localparam logic [15:0] BG_BLACK = 16'h0000;

    // One converted item handed from the converter to the emitter.
    typedef struct packed {
        logic [1:0]       mode;
        logic [BCD_W-1:0] digits;
        logic [7:0]       lo_byte;
        logic [11:0]      x_start;
        logic [11:0]      y_start;
    } t_job;

    // ASCII code of one hex or decimal digit.
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ext;
        ext = {4'b0, nib};
        if (nib < 4'd10) begin
            return ASCII_ZERO + ext;
        end
        return ASCII_HEX_OFS + ext;
    endfunction

endpackage

// ----- rtl/nadf_bcd.sv -----
// Bit-serial binary to BCD converter (shift and add three), one bit per cycle.
module nadf_bcd (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [1:0]           i_mode,
    input  logic [31:0]          i_value,
    input  logic [11:0]          i_x_start,
    input  logic [11:0]          i_y_start,
    input  logic                 i_take,
    output logic                 o_idle,
    output logic                 o_hold,
    output nadf_pkg::t_job       o_job
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]                    r_state, n_state;
    logic [4:0]                    r_cnt;
    logic [nadf_pkg::VALUE_W-1:0]  r_bin;
    logic [nadf_pkg::BCD_W-1:0]    r_bcd;
    logic [nadf_pkg::BCD_W-1:0]    n_adj;
    logic [1:0]                    r_mode;
    logic [7:0]                    r_lo_byte;
    logic [11:0]                   r_x;
    logic [11:0]                   r_y;

    // Add three to every BCD digit of five or more before the next shift.
    always_comb begin
        for (int g = 0; g < nadf_pkg::DIGITS; g++) begin
            if (r_bcd[g*4 +: 4] >= 4'd5) begin
                n_adj[g*4 +: 4] = r_bcd[g*4 +: 4] + 4'd3;
            end else begin
                n_adj[g*4 +: 4] = r_bcd[g*4 +: 4];
            end
        end
    end

    // Sequencer: load, shift 32 bits, then hold the result for the emitter.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_start) n_state = ST_RUN;
            ST_RUN:  if (r_cnt == 5'd31) n_state = ST_HOLD;
            ST_HOLD: if (i_take) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_RUN) begin
                r_cnt <= r_cnt + 5'd1;
            end else begin
                r_cnt <= '0;
            end
        end
    end

    // Datapath shift registers and captured item fields.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_start) begin
            if (i_mode == nadf_pkg::MODE_BYTE) begin
                r_bin <= {24'b0, i_value[7:0]};
            end else begin
                r_bin <= i_value;
            end
            r_bcd     <= '0;
            r_mode    <= i_mode;
            r_lo_byte <= i_value[7:0];
            r_x       <= i_x_start;
            r_y       <= i_y_start;
        end else if (r_state == ST_RUN) begin
            r_bcd <= {n_adj[nadf_pkg::BCD_W-2:0], r_bin[nadf_pkg::VALUE_W-1]};
            r_bin <= {r_bin[nadf_pkg::VALUE_W-2:0], 1'b0};
        end
    end

    assign o_idle          = (r_state == ST_IDLE);
    assign o_hold          = (r_state == ST_HOLD);
    assign o_job.mode      = r_mode;
    assign o_job.digits    = r_bcd;
    assign o_job.lo_byte   = r_lo_byte;
    assign o_job.x_start   = r_x;
    assign o_job.y_start   = r_y;

endmodule

// ----- rtl/nadf_emit.sv -----
// Character emitter: walks the digits one per cycle while the output is not stalled,
// applies blanking and the decimal point, and drives a registered output stage.
module nadf_emit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  nadf_pkg::t_job  i_job,
    input  logic [15:0]     i_text_color,
    output logic            o_busy,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_char_code,
    output logic [12:0]     o_char_x,
    output logic [11:0]     o_char_y,
    output logic [15:0]     o_fg_color,
    output logic [15:0]     o_bg_color,
    output logic            o_last
);

    logic                         r_busy;
    logic                         r_valid;
    logic [nadf_pkg::BCD_W-1:0]   r_dig;
    logic [3:0]                   r_pos;
    logic                         r_seen;
    logic                         r_dot_done;
    logic [1:0]                   r_mode;
    logic [12:0]                  r_x;
    logic [11:0]                  r_y;
    logic [7:0]                   r_code;
    logic [12:0]                  r_char_x;
    logic [11:0]                  r_char_y;
    logic [15:0]                  r_fg;
    logic [15:0]                  r_bg;
    logic                         r_last;

    logic       step;
    logic [3:0] cur;
    logic       forced;
    logic       put_dot;
    logic       show;
    logic       is_final;

    assign step = r_busy && (!r_valid || i_ready);
    assign cur  = r_dig[nadf_pkg::BCD_W-1 -: 4];

    // Which digits are always shown, where the point goes, which is final.
    always_comb begin
        forced   = 1'b0;
        put_dot  = 1'b0;
        is_final = (r_pos == nadf_pkg::POS_UNITS);
        unique case (r_mode)
            nadf_pkg::MODE_DEC: begin
                forced = (r_pos == nadf_pkg::POS_UNITS);
            end
            nadf_pkg::MODE_HUND: begin
                forced  = (r_pos >= nadf_pkg::POS_HUNDREDS);
                put_dot = (r_pos == nadf_pkg::POS_TENS) && !r_dot_done;
            end
            nadf_pkg::MODE_HEX: begin
                forced   = 1'b1;
                is_final = (r_pos == nadf_pkg::POS_HEX_LO);
            end
            nadf_pkg::MODE_BYTE: begin
                forced = (r_pos >= nadf_pkg::POS_HUNDREDS);
            end
            default: begin
                forced = 1'b1;
            end
        endcase
        show = put_dot || r_seen || forced || (cur != 4'd0);
    end

    // Control: busy flag and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_busy <= 1'b1;
            end else if (step && !put_dot && is_final) begin
                r_busy <= 1'b0;
            end
            if (step && show) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Digit walk and output registers.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            if (i_job.mode == nadf_pkg::MODE_HEX) begin
                r_dig <= {i_job.lo_byte, {(nadf_pkg::BCD_W-8){1'b0}}};
            end else begin
                r_dig <= i_job.digits;
            end
            r_pos      <= '0;
            r_seen     <= 1'b0;
            r_dot_done <= 1'b0;
            r_mode     <= i_job.mode;
            r_x        <= {1'b0, i_job.x_start};
            r_y        <= i_job.y_start;
        end else if (step) begin
            if (put_dot) begin
                r_dot_done <= 1'b1;
            end else begin
                r_dig  <= {r_dig[nadf_pkg::BCD_W-5:0], 4'b0};
                r_pos  <= r_pos + 4'd1;
                r_seen <= show;
            end
            if (show) begin
                r_x <= r_x + nadf_pkg::CHAR_PITCH;
            end
        end
        if (step && show) begin
            r_code   <= put_dot ? nadf_pkg::ASCII_DOT : nadf_pkg::hex_char(cur);
            r_char_x <= r_x;
            r_char_y <= r_y;
            r_fg     <= i_text_color;
            r_bg     <= (r_mode == nadf_pkg::MODE_DEC) ? nadf_pkg::BG_BLACK
                                                       : nadf_pkg::BG_WHITE;
            r_last   <= is_final && !put_dot;
        end
    end

    assign o_busy      = r_busy;
    assign o_valid     = r_valid;
    assign o_char_code = r_code;
    assign o_char_x    = r_char_x;
    assign o_char_y    = r_char_y;
    assign o_fg_color  = r_fg;
    assign o_bg_color  = r_bg;
    assign o_last      = r_last;

endmodule

// ----- rtl/number_to_ascii_digit_formatter.sv -----
// An accepted item is converted by the bit-serial BCD loop, held until the emitter is
//   free, then walked by the emitter; its first character reaches the output after the
//   blanked leading digit positions are skipped. The input accepts a new item only while
//   the converter is idle, so the BCD loop sets the item rate; the emitter (one digit
//   position per cycle while the output is not stalled) overlaps the next conversion.
// Reset is synchronous, active low: clears control state and text color to 0.
module number_to_ascii_digit_formatter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [31:0] i_value,
    input  logic [11:0] i_x_start,
    input  logic [11:0] i_y_start,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_char_code,
    output logic [12:0] o_char_x,
    output logic [11:0] o_char_y,
    output logic [15:0] o_fg_color,
    output logic [15:0] o_bg_color,
    output logic        o_last
);

    logic [15:0]     r_text_color;
    logic            conv_idle;
    logic            conv_hold;
    logic            emit_busy;
    logic            take;
    nadf_pkg::t_job  job;

    // Text color register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color <= '0;
        end else if (i_cfg_wr_en) begin
            r_text_color <= i_cfg_wr_data;
        end
    end

    assign o_in_ready = conv_idle;
    assign take       = conv_hold && !emit_busy;

    nadf_bcd u_bcd (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_in_valid),
        .i_mode    (i_mode),
        .i_value   (i_value),
        .i_x_start (i_x_start),
        .i_y_start (i_y_start),
        .i_take    (take),
        .o_idle    (conv_idle),
        .o_hold    (conv_hold),
        .o_job     (job)
    );

    nadf_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (take),
        .i_job        (job),
        .i_text_color (r_text_color),
        .o_busy       (emit_busy),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_char_code  (o_char_code),
        .o_char_x     (o_char_x),
        .o_char_y     (o_char_y),
        .o_fg_color   (o_fg_color),
        .o_bg_color   (o_bg_color),
        .o_last       (o_last)
    );

endmodule

// ----- rtl/nadf_chk.sv -----
// Port-level checks for the formatter.
module nadf_chk (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        o_in_ready,
    input  logic        o_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  o_char_code,
    input  logic [12:0] o_char_x,
    input  logic        o_last
);

    // A stalled output item keeps its character and position.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_char_code) && $stable(o_char_x))
        else $error("output item changed while stalled");

    // The final character of a value is always a digit, never the point.
    a_last_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last |->
            (o_char_code >= nadf_pkg::ASCII_ZERO && o_char_code <= nadf_pkg::ASCII_NINE) ||
            (o_char_code >= nadf_pkg::ASCII_UPPER_A &&
             o_char_code <= nadf_pkg::ASCII_UPPER_F))
        else $error("last character is not a digit");

    // After an item is taken the converter is busy for the next cycle.
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted on consecutive cycles");

    // No output item right after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind number_to_ascii_digit_formatter nadf_chk u_nadf_chk (.*);
